/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the RTL of the cache block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle
`define ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* rtl/core/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants, codes and helpers of the LFU cache with LRU tie-break.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

  // Default geometry
  localparam int unsigned ENTRIES_DEF    = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned PADDR_W = 3;

  // Configuration register
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic             REG_CAPACITY = 1'b0;  // word index of capacity

  // Request codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Request sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

  // Index width, at least one bit
  function automatic int unsigned idx_width(input int unsigned n);
    int unsigned w;
    begin
      w = $clog2(n);
      return (w < 1) ? 1 : w;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lfu_cache_lru_tiebreak_unit.sv */
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_unit
// Fully associative key-value cache, least-frequently-used replacement with
// least-recently-used tie-break, built as a chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request: cmd_i (get or
//   put), key_i and write_value_i. Output channel (out_valid_o/out_ready_i)
//   returns one transaction per request: hit_o and read_value_o.
//   A search token walks the cell chain one cell per cycle, so a request is
//   resolved once the token has crossed all ENTRIES cells with the new key.
//   A new request is taken only once the previous one has left its update
//   step. The result sits in an output register; the next request is
//   accepted while it waits. A stalled receiver holds the block in its
//   update step only when a second result is ready before the first was
//   taken. Reset empties every entry, clears occupancy and sets capacity
//   to 16. The user must write capacity over the APB port (byte address 0)
//   only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lfu_cache_lru_tiebreak_unit import lfu_pkg::*; #(
  parameter int unsigned ENTRIES    = ENTRIES_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                cmd_i,
  input  wire logic [KEY_W-1:0]    key_i,
  input  wire logic signed [DATA_W-1:0] write_value_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     hit_o,
  output logic signed [DATA_W-1:0] read_value_o,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  localparam int unsigned IW    = idx_width(ENTRIES);
  localparam int unsigned CW    = COUNT_BITS;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // Search token handed from cell to cell
  typedef struct packed {
    logic              hit_ok;
    logic [IW-1:0]     hit_idx;
    logic [IW-1:0]     hit_rank;
    logic [DATA_W-1:0] hit_data;
    logic              vic_ok;
    logic [IW-1:0]     vic_idx;
    logic [CW-1:0]     vic_cnt;
    logic [IW-1:0]     vic_rank;
    logic              free_ok;
    logic [IW-1:0]     free_idx;
  } cand_t;

  // Update broadcast to every cell
  typedef struct packed {
    logic              touch;
    logic              insert;
    logic              wr_data;
    logic              all_older;
    logic [IW-1:0]     slot;
    logic [IW-1:0]     ref_rank;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } op_t;

  state_e state_q, state_d;

  logic [CAP_W-1:0]  cap_q;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic [OCC_W-1:0]  settle_q, settle_d;
  logic              req_cmd_q;
  logic [KEY_W-1:0]  req_key_q;
  logic [DATA_W-1:0] req_data_q;
  logic              out_vld_q;
  logic              out_hit_q;
  logic [DATA_W-1:0] out_data_q;

  logic              in_fire, out_fire, upd_fire, cfg_wr;
  logic [CMP_W-1:0]  cap_eff;
  logic              full, do_insert;
  op_t               op;
  cand_t             chain [ENTRIES+1];
  cand_t             tail;

  // Handshakes
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_vld_q && out_ready_i;
  assign upd_fire   = (state_q == ST_UPDATE) && (!out_vld_q || out_ready_i);

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_q) : '0;

  // Clamp capacity to the array size and test for a full cache
  always_comb begin
    cap_eff = (CMP_W'(cap_q) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_q);
    full    = CMP_W'(occ_q) >= cap_eff;
  end

  // Cell chain
  assign chain[0] = '0;
  assign tail     = chain[ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS),
      .IDX        (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (req_key_q),
      .op_i   (op),
      .cand_i (chain[g]),
      .cand_o (chain[g+1])
    );
  end

  // Build the update from the settled token
  assign do_insert = !tail.hit_ok && (req_cmd_q == CMD_PUT) && (cap_eff != '0);

  always_comb begin
    op      = '0;
    op.key  = req_key_q;
    op.data = req_data_q;
    occ_d   = occ_q;
    if (upd_fire) begin
      if (tail.hit_ok) begin
        op.touch    = 1'b1;
        op.wr_data  = (req_cmd_q == CMD_PUT);
        op.slot     = tail.hit_idx;
        op.ref_rank = tail.hit_rank;
      end else if (do_insert) begin
        op.insert = 1'b1;
        if (full) begin
          op.slot     = tail.vic_idx;
          op.ref_rank = tail.vic_rank;
        end else begin
          op.slot      = tail.free_idx;
          op.all_older = 1'b1;
          occ_d        = occ_q + OCC_W'(1);
        end
      end
    end
  end

  // Sequence one request: scan until the token has crossed the chain, update
  always_comb begin
    state_d  = state_q;
    settle_d = settle_q;
    if (in_fire || upd_fire) begin
      settle_d = '0;
    end else if (settle_q != OCC_W'(ENTRIES)) begin
      settle_d = settle_q + OCC_W'(1);
    end
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (settle_q == OCC_W'(ENTRIES)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      settle_q  <= '0;
      occ_q     <= '0;
      cap_q     <= CAP_RESET;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      settle_q <= settle_d;
      occ_q    <= occ_d;
      if (cfg_wr) begin
        cap_q <= pwdata[CAP_W-1:0];
      end
      if (upd_fire) begin
        out_vld_q <= 1'b1;
      end else if (out_fire) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Latch the request and the result
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_cmd_q  <= cmd_i;
      req_key_q  <= key_i;
      req_data_q <= write_value_i;
    end
    if (upd_fire) begin
      out_hit_q  <= tail.hit_ok;
      out_data_q <= (tail.hit_ok && req_cmd_q == CMD_GET) ? tail.hit_data : '0;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign hit_o        = out_hit_q;
  assign read_value_o = out_data_q;

  // Checks
  `ASSERT_ALWAYS(a_upd_settled, !upd_fire || settle_q == OCC_W'(ENTRIES), "update before chain settled")
  `ASSERT_NEXT(a_accept_scan, in_fire, state_q == ST_SCAN, "accepted request did not start a scan")
  `ASSERT_ALWAYS(a_out_from_upd, !$rose(out_vld_q) || $past(state_q == ST_UPDATE), "result without update")
  `ASSERT_ALWAYS(a_occ_bound, occ_q <= OCC_W'(ENTRIES), "occupancy above entry count")

endmodule

`default_nettype wire

/* rtl/core/lfu_cell.sv */
// ----------------------------------------------------------------------------
// lfu_cell
// One cache entry: holds key, data, use count and recency rank, applies the
// broadcast update and merges its entry into the search token of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cell import lfu_pkg::*; #(
  parameter int unsigned ENTRIES    = ENTRIES_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned IDX        = 0
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic [KEY_W-1:0] key_i,
  input  wire logic [2*idx_width(ENTRIES)+KEY_W+DATA_W+3:0] op_i,
  input  wire logic [3*idx_width(ENTRIES)+2*idx_width(ENTRIES)+DATA_W+COUNT_BITS+2:0] cand_i,
  output logic [3*idx_width(ENTRIES)+2*idx_width(ENTRIES)+DATA_W+COUNT_BITS+2:0] cand_o
);

  localparam int unsigned IW = idx_width(ENTRIES);
  localparam int unsigned CW = COUNT_BITS;

  // Search token handed from cell to cell
  typedef struct packed {
    logic              hit_ok;
    logic [IW-1:0]     hit_idx;
    logic [IW-1:0]     hit_rank;
    logic [DATA_W-1:0] hit_data;
    logic              vic_ok;
    logic [IW-1:0]     vic_idx;
    logic [CW-1:0]     vic_cnt;
    logic [IW-1:0]     vic_rank;
    logic              free_ok;
    logic [IW-1:0]     free_idx;
  } cand_t;

  // Update broadcast to every cell
  typedef struct packed {
    logic              touch;
    logic              insert;
    logic              wr_data;
    logic              all_older;
    logic [IW-1:0]     slot;
    logic [IW-1:0]     ref_rank;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } op_t;

  op_t   op;
  cand_t cand_in, cand_d, cand_q;

  logic              valid_q, valid_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [IW-1:0]     rank_q, rank_d;
  logic              is_me;

  assign op      = op_t'(op_i);
  assign cand_in = cand_t'(cand_i);
  assign cand_o  = cand_q;
  assign is_me   = (op.slot == IW'(IDX));

  // Apply the broadcast update to this entry
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    data_d  = data_q;
    cnt_d   = cnt_q;
    rank_d  = rank_q;
    if (op.touch || op.insert) begin
      if (is_me) begin
        rank_d = '0;
        if (op.insert) begin
          valid_d = 1'b1;
          key_d   = op.key;
          data_d  = op.data;
          cnt_d   = CW'(1);
        end else begin
          if (op.wr_data) begin
            data_d = op.data;
          end
          if (cnt_q != {CW{1'b1}}) begin
            cnt_d = cnt_q + CW'(1);
          end
        end
      end else if (valid_q && (op.all_older || rank_q < op.ref_rank)) begin
        rank_d = rank_q + IW'(1);
      end
    end
  end

  // Merge this entry into the search token
  always_comb begin
    cand_d = cand_in;
    if (valid_q && key_q == key_i) begin
      cand_d.hit_ok   = 1'b1;
      cand_d.hit_idx  = IW'(IDX);
      cand_d.hit_rank = rank_q;
      cand_d.hit_data = data_q;
    end
    if (valid_q && (!cand_in.vic_ok || cnt_q < cand_in.vic_cnt ||
        (cnt_q == cand_in.vic_cnt && rank_q > cand_in.vic_rank))) begin
      cand_d.vic_ok   = 1'b1;
      cand_d.vic_idx  = IW'(IDX);
      cand_d.vic_cnt  = cnt_q;
      cand_d.vic_rank = rank_q;
    end
    if (!cand_in.free_ok && !valid_q) begin
      cand_d.free_ok  = 1'b1;
      cand_d.free_idx = IW'(IDX);
    end
  end

  // Hold the valid bit and the token under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cand_q  <= '0;
    end else begin
      valid_q <= valid_d;
      cand_q  <= cand_d;
    end
  end

  // Entry payload
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    data_q <= data_d;
    cnt_q  <= cnt_d;
    rank_q <= rank_d;
  end

endmodule

`default_nettype wire
